// File: src/xdbt_pkg.sv
// shared types, codes and a helper function for the xor-distance bucket table
// depends on nothing; imported by xor_distance_bucket_table_top
`default_nettype none

package xdbt_pkg;

    // request kinds
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // update outcomes
    localparam logic [2:0] ACT_ADDED     = 3'd0;
    localparam logic [2:0] ACT_REFRESHED = 3'd1;
    localparam logic [2:0] ACT_STALE     = 3'd2;
    localparam logic [2:0] ACT_FULL      = 3'd3;
    localparam logic [2:0] ACT_OWN_ID    = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE       = 3'd3;

    localparam logic [15:0] STALE_RESET = 16'd900;  // fifteen minutes

    // the 160-bit distance is searched in five 32-bit chunks
    localparam logic [2:0] LAST_CHUNK = 3'd4;

    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_middle;
        logic [31:0] id_low;
        logic [31:0] host;
        logic [15:0] port;
        logic [31:0] added;
    } entry_t;

    // leading zeros of a nonzero 32-bit word
    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (v[b])
            begin
                n = 5'(31 - b);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: src/xor_distance_bucket_table_top.sv
// xor-distance bucket routing table: sequencer plus one synchronous entry memory
// depends on xdbt_pkg
//
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// request | in        | req_valid/req_ready  | kind, peer_*, now_seconds, *_select
// result  | out       | rsp_valid/rsp_ready  | bucket_used, action, slot_*, totals
//
// one request at a time; an update runs the distance search (one 32-bit chunk
// per cycle), then a memory read and a compare for each stored slot passed, and
// an empty or full check that ends the scan unless a refresh or a stale entry
// ends it first, then a finish state
// a query walks its bucket the same way, a read reads at most one slot; the
// sequencer returns to idle before the next request; the synchronous memory
// read splits each slot into a read state and a compare state; after reset a
// clearing pass zeroes the fill counts one bucket at a time, with req_ready low
// a result waiting on rsp_ready does not block the next request from entering
`default_nettype none

module xor_distance_bucket_table_top
    import xdbt_pkg::*;
#(
    parameter int NUM_BUCKETS      = 160,
    parameter int SLOTS_PER_BUCKET = 8
)(
    input  wire                  clk,
    input  wire                  rst_n,
    // configuration writes
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [63:0]           cfg_data,
    // request channel
    input  wire                  req_valid,
    output logic                 req_ready,
    input  wire [1:0]            kind,
    input  wire [63:0]           peer_id_high,
    input  wire [63:0]           peer_id_middle,
    input  wire [31:0]           peer_id_low,
    input  wire [31:0]           peer_host,
    input  wire [15:0]           peer_port,
    input  wire [31:0]           now_seconds,
    input  wire [7:0]            bucket_select,
    input  wire [2:0]            slot_select,
    // result channel
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output logic [7:0]           bucket_used,
    output logic [2:0]           action,
    output logic                 needs_update,
    output logic                 slot_valid,
    output logic [31:0]          slot_host,
    output logic [15:0]          slot_port,
    output logic [63:0]          slot_id_high,
    output logic [63:0]          slot_id_middle,
    output logic [31:0]          slot_id_low,
    output logic [7:0]           deepest_bucket,
    output logic [10:0]          entry_total
);

    localparam int DEPTH  = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam logic [ADDR_W-1:0] SLOTS_A  = ADDR_W'(SLOTS_PER_BUCKET);
    localparam logic [CNT_W-1:0]  SLOTS_C  = CNT_W'(SLOTS_PER_BUCKET);
    localparam logic [7:0]        NB8      = 8'(NUM_BUCKETS);
    localparam logic [7:0]        LAST_B8  = 8'(NUM_BUCKETS - 1);
    localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [4:0]        SLOTS5   = 5'(SLOTS_PER_BUCKET);
    localparam logic [10:0]       TOTAL_MAX = 11'h7FF;

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LZC   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_DONE  = 6'b010000,
        S_CLEAR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [63:0] self_high_reg, self_middle_reg;
    logic [31:0] self_low_reg;
    logic [15:0] stale_reg;

    // latched request
    logic [1:0]  kind_reg, kind_next;
    logic [63:0] id_high_reg, id_high_next;
    logic [63:0] id_middle_reg, id_middle_next;
    logic [31:0] id_low_reg, id_low_next;
    logic [31:0] host_reg, host_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] now_reg, now_next;

    // walk state and pending result
    logic [BKT_W-1:0] bucket_reg, bucket_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [2:0]       chunk_reg, chunk_next;
    logic [7:0]       bu_reg, bu_next;
    logic [2:0]       act_reg, act_next;
    logic             needs_reg, needs_next;
    logic             sval_reg, sval_next;
    logic [BKT_W-1:0] clr_reg, clr_next;

    // table bookkeeping: slots fill in order and are never freed, so a
    // per-bucket count stands in for per-entry valid bits
    logic [CNT_W-1:0] fill_mem [NUM_BUCKETS];
    logic [CNT_W-1:0] fill_q;
    logic             fill_we;
    logic [BKT_W-1:0] fill_waddr;
    logic [CNT_W-1:0] fill_wdata;
    logic [7:0]       deepest_reg;
    logic [10:0]      total_reg;

    // entry memory
    entry_t            entry_mem [DEPTH];
    entry_t            rd_q;
    entry_t            mem_wdata;
    logic              mem_we, mem_re, add_hit;
    logic [ADDR_W-1:0] mem_addr;

    logic             rsp_load;
    logic [CNT_W-1:0] fill_cur;
    logic [159:0]     xor_dist;
    logic [31:0]      chunk_bits;
    logic [7:0]       lz, lz_bucket;
    logic             stale;

    assign req_ready = (state_reg == S_IDLE);
    // fill count of the bucket being walked, registered from the next-state bucket
    assign fill_cur  = fill_q;
    assign mem_addr  = ADDR_W'(bucket_reg) * SLOTS_A + ADDR_W'(slot_reg);
    assign xor_dist  = {id_high_reg ^ self_high_reg, id_middle_reg ^ self_middle_reg,
                        id_low_reg ^ self_low_reg};
    // entry is stale when added + limit < now, no wrap
    assign stale     = ({1'b0, rd_q.added} + 33'(stale_reg)) < {1'b0, now_reg};

    always_comb
    begin
        case (chunk_reg)
            3'd0:    chunk_bits = xor_dist[159:128];
            3'd1:    chunk_bits = xor_dist[127:96];
            3'd2:    chunk_bits = xor_dist[95:64];
            3'd3:    chunk_bits = xor_dist[63:32];
            default: chunk_bits = xor_dist[31:0];
        endcase
    end

    assign lz        = {chunk_reg, 5'b0} + {3'b0, lzc32(chunk_bits)};
    assign lz_bucket = (lz >= NB8) ? LAST_B8 : lz;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_high_next   = id_high_reg;
        id_middle_next = id_middle_reg;
        id_low_next    = id_low_reg;
        host_next      = host_reg;
        port_next      = port_reg;
        now_next       = now_reg;
        bucket_next    = bucket_reg;
        slot_next      = slot_reg;
        chunk_next     = chunk_reg;
        bu_next        = bu_reg;
        act_next       = act_reg;
        needs_next     = needs_reg;
        sval_next      = sval_reg;
        clr_next       = clr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        add_hit        = 1'b0;
        rsp_load       = 1'b0;
        fill_we        = 1'b0;
        fill_waddr     = bucket_reg;
        fill_wdata     = fill_cur + CNT_W'(1);
        mem_wdata      = '{id_high: id_high_reg, id_middle: id_middle_reg,
                           id_low: id_low_reg, host: host_reg, port: port_reg,
                           added: now_reg};

        case (state_reg)
            S_CLEAR:
            begin
                // one bucket count zeroed per cycle
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                clr_next   = clr_reg + BKT_W'(1);
                if (clr_reg == LAST_BKT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next      = kind;
                    id_high_next   = peer_id_high;
                    id_middle_next = peer_id_middle;
                    id_low_next    = peer_id_low;
                    host_next      = peer_host;
                    port_next      = peer_port;
                    now_next       = now_seconds;
                    bu_next        = bucket_select;
                    act_next       = ACT_ADDED;
                    needs_next     = 1'b0;
                    sval_next      = 1'b0;
                    bucket_next    = BKT_W'(bucket_select);
                    chunk_next     = 3'd0;
                    slot_next      = '0;
                    state_next     = S_DONE;
                    case (kind)
                        KIND_UPDATE:
                        begin
                            state_next = S_LZC;
                        end
                        KIND_QUERY:
                        begin
                            if (bucket_select < NB8)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_READ:
                        begin
                            slot_next = CNT_W'(slot_select);
                            if (bucket_select < NB8 && {2'b0, slot_select} < SLOTS5)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_LZC:
            begin
                if (chunk_bits != 32'd0)
                begin
                    bucket_next = BKT_W'(lz_bucket);
                    bu_next     = lz_bucket;
                    state_next  = S_SCAN;
                end
                else if (chunk_reg == LAST_CHUNK)
                begin
                    act_next   = ACT_OWN_ID;
                    bu_next    = 8'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    chunk_next = chunk_reg + 3'd1;
                end
            end

            S_SCAN:
            begin
                case (kind_reg)
                    KIND_UPDATE:
                    begin
                        if (slot_reg == SLOTS_C)
                        begin
                            act_next   = ACT_FULL;
                            state_next = S_DONE;
                        end
                        else if (slot_reg >= fill_cur)
                        begin
                            mem_we     = 1'b1;
                            add_hit    = 1'b1;
                            fill_we    = 1'b1;
                            act_next   = ACT_ADDED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (slot_reg == SLOTS_C)
                        begin
                            state_next = S_DONE;
                        end
                        else if (slot_reg >= fill_cur)
                        begin
                            needs_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                    end
                    default:
                    begin
                        if (slot_reg < fill_cur)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end

            S_EVAL:
            begin
                case (kind_reg)
                    KIND_UPDATE:
                    begin
                        if (rd_q.host == host_reg)
                        begin
                            // refresh keeps the stored id
                            mem_we     = 1'b1;
                            mem_wdata  = '{id_high: rd_q.id_high, id_middle: rd_q.id_middle,
                                           id_low: rd_q.id_low, host: rd_q.host,
                                           port: port_reg, added: now_reg};
                            act_next   = ACT_REFRESHED;
                            state_next = S_DONE;
                        end
                        else if (stale)
                        begin
                            act_next   = ACT_STALE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            slot_next  = slot_reg + CNT_W'(1);
                            state_next = S_SCAN;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (stale)
                        begin
                            needs_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            slot_next  = slot_reg + CNT_W'(1);
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        sval_next  = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!rsp_valid || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // request and walk payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_high_reg   <= id_high_next;
        id_middle_reg <= id_middle_next;
        id_low_reg    <= id_low_next;
        host_reg      <= host_next;
        port_reg      <= port_next;
        now_reg       <= now_next;
        bucket_reg    <= bucket_next;
        slot_reg      <= slot_next;
        chunk_reg     <= chunk_next;
        bu_reg        <= bu_next;
        act_reg       <= act_next;
        needs_reg     <= needs_next;
        sval_reg      <= sval_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_high_reg   <= '0;
            self_middle_reg <= '0;
            self_low_reg    <= '0;
            stale_reg       <= STALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_HIGH:   self_high_reg   <= cfg_data;
                CFG_SELF_MIDDLE: self_middle_reg <= cfg_data;
                CFG_SELF_LOW:    self_low_reg    <= cfg_data[31:0];
                CFG_STALE:       stale_reg       <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // fill count memory, read at the bucket of the next cycle
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_q <= fill_mem[bucket_next];
    end

    // deepest bucket, add counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deepest_reg <= '0;
            total_reg   <= '0;
        end
        else if (add_hit)
        begin
            if (bu_reg > deepest_reg)
            begin
                deepest_reg <= bu_reg;
            end
            if (total_reg != TOTAL_MAX)
            begin
                total_reg <= total_reg + 11'd1;
            end
        end
    end

    // entry memory, read data registered on mem_re
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= entry_mem[mem_addr];
        end
    end

    // result register, frees the sequencer while the result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            bucket_used    <= bu_reg;
            action         <= act_reg;
            needs_update   <= needs_reg;
            slot_valid     <= sval_reg;
            slot_host      <= sval_reg ? rd_q.host      : 32'd0;
            slot_port      <= sval_reg ? rd_q.port      : 16'd0;
            slot_id_high   <= sval_reg ? rd_q.id_high   : 64'd0;
            slot_id_middle <= sval_reg ? rd_q.id_middle : 64'd0;
            slot_id_low    <= sval_reg ? rd_q.id_low    : 32'd0;
            deepest_bucket <= deepest_reg;
            entry_total    <= total_reg;
        end
    end

    // memory is written only while walking a bucket
    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN || state_reg == S_EVAL))
        else $error("entry write outside bucket walk");

    // a bucket never holds more entries than slots
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (fill_cur <= SLOTS_C))
        else $error("bucket fill count beyond slot count");

    // results appear only after the finish state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finish state");

    // add counter moves only on an add
    a_total_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> $past(add_hit))
        else $error("add counter changed without an add");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire
